FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DSHTX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dshtx assertion failed");
`define DSHTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dshtx assertion failed");
`else
`define DSHTX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DSHTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/dshtx_pkg.sv
// ----------------------------------------------------------------------------
// DShot frame transmitter package
// Word kinds, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package dshtx_pkg;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ZERO_LOW  = 3'd3,
        CFG_MOTOR_CNT = 3'd4
    } t_cfg_idx;

    localparam logic [9:0]  RST_ONE_HIGH   = 10'd110;
    localparam logic [9:0]  RST_ONE_LOW    = 10'd36;
    localparam logic [9:0]  RST_ZERO_HIGH  = 10'd47;
    localparam logic [9:0]  RST_ZERO_LOW   = 10'd100;
    localparam logic [2:0]  RST_MOTOR_CNT  = 3'd0;
    localparam logic [10:0] TELEM_LIMIT    = 11'd48;
    localparam logic [3:0]  NIBBLE_MASK    = 4'hF;
    localparam logic [4:0]  FRAME_BITS     = 5'd16;

    typedef struct packed {
        logic [9:0] one_high;
        logic [9:0] one_low;
        logic [9:0] zero_high;
        logic [9:0] zero_low;
        logic [2:0] motor_cnt;
    } t_cfg;

    typedef struct packed {
        logic        refused;
        logic [15:0] packet;
        logic        busy_res;
        logic [1:0]  active_motor;
        logic        line_high;
    } t_result;

endpackage

FILE: sv/dshtx_encode.sv
// ----------------------------------------------------------------------------
// DShot packet encoder
// Throttle to 16-bit packet: telemetry bit and XOR nibble checksum.
// ----------------------------------------------------------------------------
module dshtx_encode (
    input  logic [10:0] i_throttle,
    output logic [15:0] o_packet
);

    logic        telem;
    logic [11:0] value;
    logic [3:0]  crc;

    assign telem    = (i_throttle != 11'd0) && (i_throttle < dshtx_pkg::TELEM_LIMIT);
    assign value    = {i_throttle, telem};
    assign crc      = (value[3:0] ^ value[7:4] ^ value[11:8]) & dshtx_pkg::NIBBLE_MASK;
    assign o_packet = {value, crc};

endmodule

FILE: sv/dshtx_cfg.sv
// ----------------------------------------------------------------------------
// DShot configuration registers
// Bit timing and motor count, written through the configuration channel.
// ----------------------------------------------------------------------------
module dshtx_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [2:0]       i_index,
    input  logic [9:0]       i_data,
    output dshtx_pkg::t_cfg  o_cfg
);

    dshtx_pkg::t_cfg r_cfg;
    dshtx_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (dshtx_pkg::t_cfg_idx'(i_index))
                dshtx_pkg::CFG_ONE_HIGH:  n_cfg.one_high  = i_data;
                dshtx_pkg::CFG_ONE_LOW:   n_cfg.one_low   = i_data;
                dshtx_pkg::CFG_ZERO_HIGH: n_cfg.zero_high = i_data;
                dshtx_pkg::CFG_ZERO_LOW:  n_cfg.zero_low  = i_data;
                dshtx_pkg::CFG_MOTOR_CNT: n_cfg.motor_cnt = i_data[2:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high  <= dshtx_pkg::RST_ONE_HIGH;
            r_cfg.one_low   <= dshtx_pkg::RST_ONE_LOW;
            r_cfg.zero_high <= dshtx_pkg::RST_ZERO_HIGH;
            r_cfg.zero_low  <= dshtx_pkg::RST_ZERO_LOW;
            r_cfg.motor_cnt <= dshtx_pkg::RST_MOTOR_CNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/dshtx_engine.sv
// ----------------------------------------------------------------------------
// DShot send engine
// Packet store, bit shifter and phase counter; one word per advance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dshtx_engine #(
    parameter int NUM_MOTORS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [1:0]          i_kind,
    input  logic [1:0]          i_motor,
    input  logic [15:0]         i_packet,
    input  dshtx_pkg::t_cfg     i_cfg,
    output dshtx_pkg::t_result  o_result
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int AW    = (IDX_W > 3) ? IDX_W : 3;

    logic [15:0] r_store [NUM_MOTORS];
    logic [15:0] r_shift;
    logic [4:0]  r_bits_left;
    logic [9:0]  r_phase;
    logic        r_low;
    logic [2:0]  r_cur;
    logic        r_sending;

    logic [15:0] n_shift;
    logic [4:0]  n_bits_left;
    logic [9:0]  n_phase;
    logic        n_low;
    logic [2:0]  n_cur;
    logic        n_sending;

    logic [2:0]    cnt;
    logic [9:0]    limit_raw;
    logic [9:0]    limit;
    logic [9:0]    phase_inc;
    logic [2:0]    ld_motor;
    logic [AW-1:0] ld_wide;
    logic [AW-1:0] wr_wide;
    logic [15:0]   ld_word;
    logic          ld_en;
    logic          store_wr;
    logic          refused;

    assign cnt = (32'(i_cfg.motor_cnt) > NUM_MOTORS) ? 3'(NUM_MOTORS) : i_cfg.motor_cnt;

    always_comb begin
        unique case ({r_low, r_shift[15]})
            2'b01:   limit_raw = i_cfg.one_high;
            2'b00:   limit_raw = i_cfg.zero_high;
            2'b11:   limit_raw = i_cfg.one_low;
            default: limit_raw = i_cfg.zero_low;
        endcase
    end

    assign limit     = (limit_raw == 10'd0) ? 10'd1 : limit_raw;
    assign phase_inc = r_phase + 10'd1;
    assign ld_wide   = AW'(ld_motor);
    assign wr_wide   = AW'(i_motor);
    assign ld_word   = r_store[ld_wide[IDX_W-1:0]];
    assign store_wr  = i_advance && (dshtx_pkg::t_kind'(i_kind) == dshtx_pkg::KIND_SET)
                       && (32'(i_motor) < NUM_MOTORS);

    always_comb begin
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_phase     = r_phase;
        n_low       = r_low;
        n_cur       = r_cur;
        n_sending   = r_sending;
        ld_en       = 1'b0;
        ld_motor    = 3'd0;
        refused     = 1'b0;
        unique case (dshtx_pkg::t_kind'(i_kind))
            dshtx_pkg::KIND_SET: begin
                n_sending = r_sending;
            end
            dshtx_pkg::KIND_START: begin
                if (r_sending) begin
                    refused = 1'b1;
                end else if (cnt != 3'd0) begin
                    n_sending = 1'b1;
                    ld_en     = 1'b1;
                end
            end
            dshtx_pkg::KIND_TICK: begin
                if (r_sending) begin
                    if (phase_inc < limit) begin
                        n_phase = phase_inc;
                    end else begin
                        n_phase = 10'd0;
                        if (!r_low) begin
                            n_low = 1'b1;
                        end else begin
                            n_low       = 1'b0;
                            n_shift     = {r_shift[14:0], 1'b0};
                            n_bits_left = r_bits_left - 5'd1;
                            if (r_bits_left == 5'd1) begin
                                if ((r_cur + 3'd1) < cnt) begin
                                    ld_en    = 1'b1;
                                    ld_motor = r_cur + 3'd1;
                                end else begin
                                    n_sending = 1'b0;
                                    n_cur     = 3'd0;
                                    n_shift   = 16'd0;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                n_sending = r_sending;
            end
        endcase
        if (ld_en) begin
            n_cur       = ld_motor;
            n_shift     = ld_word;
            n_bits_left = dshtx_pkg::FRAME_BITS;
            n_phase     = 10'd0;
            n_low       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_store[k] <= 16'd0;
            end
            r_shift     <= 16'd0;
            r_bits_left <= 5'd0;
            r_phase     <= 10'd0;
            r_low       <= 1'b0;
            r_cur       <= 3'd0;
            r_sending   <= 1'b0;
        end else begin
            if (store_wr) begin
                r_store[wr_wide[IDX_W-1:0]] <= i_packet;
            end
            if (i_advance) begin
                r_shift     <= n_shift;
                r_bits_left <= n_bits_left;
                r_phase     <= n_phase;
                r_low       <= n_low;
                r_cur       <= n_cur;
                r_sending   <= n_sending;
            end
        end
    end

    assign o_result.line_high    = n_sending && !n_low;
    assign o_result.active_motor = n_sending ? n_cur[1:0] : 2'd0;
    assign o_result.busy_res     = n_sending;
    assign o_result.packet       = (dshtx_pkg::t_kind'(i_kind) == dshtx_pkg::KIND_SET)
                                   ? i_packet : 16'd0;
    assign o_result.refused      = refused;

    `DSHTX_ASSERT_IMPL(a_bits_live, i_clk, i_rst_n, r_sending,
        (r_bits_left != 5'd0) && (r_bits_left <= dshtx_pkg::FRAME_BITS))
    `DSHTX_ASSERT_IMPL(a_idle_clean, i_clk, i_rst_n, !r_sending,
        (r_cur == 3'd0) && (r_shift == 16'd0) && !r_low && (r_phase == 10'd0))
    `DSHTX_ASSERT_NEXT(a_refuse_keeps, i_clk, i_rst_n, i_advance && refused,
        r_sending && $stable(r_cur) && $stable(r_bits_left))
    `DSHTX_ASSERT_IMPL(a_cur_in_range, i_clk, i_rst_n, r_sending, r_cur < cnt)

endmodule

FILE: sv/dshot600_frame_transmitter.sv
// ----------------------------------------------------------------------------
// DShot600 frame transmitter
// Stores encoded packets for up to NUM_MOTORS motors and steps their frames
// bit by bit on tick words, reporting line level and status per word.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   i_s_axis_tvalid/o_..tready tdata: throttle, motor; tuser: kind
//  m_axis    out  o_m_axis_tvalid/i_..tready tdata: line_high .. refused
//  cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
//  One word per cycle sustained while the output is not stalled; a result
//  leaves through the input register, then the result register.
//  Reset is synchronous, active low, and clears store, state and config.
//  A stalled result holds in the result register; the input register fills
//  behind it, then tready drops.
// ----------------------------------------------------------------------------
module dshot600_frame_transmitter #(
    parameter int NUM_MOTORS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [10:0] throttle, [12:11] motor
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [0] line_high, [2:1] active_motor,
                                          // [3] busy_res, [19:4] packet, [20] refused
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic [10:0] r_throttle;
    logic [1:0]  r_motor;

    logic               r_out_valid;
    dshtx_pkg::t_result r_out;

    logic               advance;
    logic               take_in;
    logic [15:0]        packet;
    dshtx_pkg::t_cfg    cfg;
    dshtx_pkg::t_result result;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign take_in         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_kind     <= i_s_axis_tuser;
            r_throttle <= i_s_axis_tdata[10:0];
            r_motor    <= i_s_axis_tdata[12:11];
        end
    end

    dshtx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    dshtx_encode u_encode (
        .i_throttle (r_throttle),
        .o_packet   (packet)
    );

    dshtx_engine #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_kind    (r_kind),
        .i_motor   (r_motor),
        .i_packet  (packet),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out};

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// DShot600 frame transmitter testbench
// Streams set, start, tick and unused-kind words under random gaps and
// back-pressure and rewrites the timing registers between phases. A
// behavioral copy of the packet encoder and bit timer predicts every status
// word, and each result word is compared with it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MOTORS       = 4;
    localparam int          RANDOM_WORDS = 450;
    localparam int          PHASE_WORDS  = 150;
    localparam int          LONG_HOLD    = 300;
    localparam int          TICK_CHUNK   = 16;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] throttle;
        logic [1:0]  motor;
    } t_word;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   tx_valid = 1'b0;
    t_word                  tx_word  = '0;
    logic                   rx_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    dshtx_pkg::t_cfg_idx    cfg_index = dshtx_pkg::CFG_ONE_HIGH;
    logic [9:0]             cfg_data  = '0;

    wire         s_tready;
    wire  [15:0] s_tdata = {3'b000, tx_word.motor, tx_word.throttle};
    wire  [1:0]  s_tuser = tx_word.kind;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire         cfg_ready;

    t_word                  word_q [$];
    dshtx_pkg::t_result     status_q [$];
    int          fail_cnt = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          rx_hold_left = 0;
    bit          rx_hold_req = 1'b0;
    bit          rx_hold_done = 1'b0;
    bit          calm = 1'b0;

    // behavioral state of the transmitter
    dshtx_pkg::t_cfg cfg_shadow = '{dshtx_pkg::RST_ONE_HIGH, dshtx_pkg::RST_ONE_LOW,
                                    dshtx_pkg::RST_ZERO_HIGH, dshtx_pkg::RST_ZERO_LOW,
                                    dshtx_pkg::RST_MOTOR_CNT};
    logic [15:0] pkt_mem [MOTORS] = '{default: '0};
    logic [15:0] tx_shift  = '0;
    logic [4:0]  bits_rem  = '0;
    logic [9:0]  tick_cnt  = '0;
    logic        low_half  = 1'b0;
    logic [1:0]  cur_motor = '0;
    logic        frame_on  = 1'b0;

    dshot600_frame_transmitter #(.NUM_MOTORS(MOTORS)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (tx_valid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] encode_dshot(logic [10:0] thr);
        logic [11:0] v;
        logic [3:0]  sum;
        v = {thr, 1'b0};
        if (thr != '0 && thr < dshtx_pkg::TELEM_LIMIT) v[0] = 1'b1;
        sum = (v[3:0] ^ v[7:4] ^ v[11:8]) & dshtx_pkg::NIBBLE_MASK;
        return {v, sum};
    endfunction

    function automatic int motors_enabled();
        return (cfg_shadow.motor_cnt > MOTORS) ? MOTORS : int'(cfg_shadow.motor_cnt);
    endfunction

    function automatic void load_motor(logic [1:0] m);
        cur_motor = m;
        tx_shift  = pkt_mem[m];
        bits_rem  = dshtx_pkg::FRAME_BITS;
        tick_cnt  = '0;
        low_half  = 1'b0;
    endfunction

    function automatic void advance_tick();
        logic [9:0] span;
        if (!low_half) span = tx_shift[15] ? cfg_shadow.one_high : cfg_shadow.zero_high;
        else           span = tx_shift[15] ? cfg_shadow.one_low  : cfg_shadow.zero_low;
        if (span == '0) span = 10'd1;
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt < span) return;
        tick_cnt = '0;
        if (!low_half) begin
            low_half = 1'b1;
            return;
        end
        low_half = 1'b0;
        tx_shift = tx_shift << 1;
        if (bits_rem != '0) bits_rem = bits_rem - 5'd1;
        if (bits_rem != '0) return;
        if (int'(cur_motor) + 1 < motors_enabled()) begin
            load_motor(cur_motor + 2'd1);
        end else begin
            frame_on  = 1'b0;
            cur_motor = '0;
            tx_shift  = '0;
        end
    endfunction

    function automatic dshtx_pkg::t_result predict_status(t_word w);
        dshtx_pkg::t_result r;
        r = '0;
        case (w.kind)
            dshtx_pkg::KIND_SET: begin
                r.packet = encode_dshot(w.throttle);
                pkt_mem[w.motor] = r.packet;
            end
            dshtx_pkg::KIND_START: begin
                if (frame_on) begin
                    r.refused = 1'b1;
                end else if (motors_enabled() > 0) begin
                    frame_on = 1'b1;
                    load_motor(2'd0);
                end
            end
            dshtx_pkg::KIND_TICK: begin
                if (frame_on) advance_tick();
            end
            default: ;
        endcase
        r.line_high    = frame_on && !low_half;
        r.active_motor = frame_on ? cur_motor : 2'd0;
        r.busy_res     = frame_on;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        t_word nxt;
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (tx_valid && s_tready) begin
                status_q.push_back(predict_status(tx_word));
            end
            if (!tx_valid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    tx_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    tx_gap = $urandom_range(0, 4);
                    tx_valid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    nxt = word_q.pop_front();
                    tx_word  <= nxt;
                    tx_valid <= 1'b1;
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        dshtx_pkg::t_result got;
        dshtx_pkg::t_result want;
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (m_tvalid && rx_ready) begin
                got = dshtx_pkg::t_result'(m_tdata[20:0]);
                if (status_q.size() == 0) begin
                    $error("result word with no prediction pending");
                    fail_cnt++;
                end else begin
                    want = status_q.pop_front();
                    check_field("line_high", want.line_high, got.line_high);
                    check_field("active_motor", want.active_motor, got.active_motor);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("packet", want.packet, got.packet);
                    check_field("refused", want.refused, got.refused);
                end
            end
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rx_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                rx_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(0, 4);
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(logic [1:0] kind, logic [10:0] thr, logic [1:0] m);
        t_word w;
        w.kind     = kind;
        w.throttle = thr;
        w.motor    = m;
        word_q.push_back(w);
    endtask

    task automatic push_filler(logic [1:0] kind);
        push_word(kind, 11'($urandom), 2'($urandom));
    endtask

    function automatic logic [10:0] pick_throttle();
        case ($urandom_range(0, 5))
            0: return 11'($urandom_range(0, 47));
            1: begin
                case ($urandom_range(0, 4))
                    0: return 11'd0;
                    1: return 11'd1;
                    2: return 11'd47;
                    3: return 11'd48;
                    default: return 11'd2047;
                endcase
            end
            default: return 11'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (word_q.size() != 0 || tx_valid || status_q.size() != 0) @(negedge i_clk);
    endtask

    // finish any frame in flight so the registers can change
    task automatic settle();
        wait_drained();
        while (frame_on) begin
            repeat (TICK_CHUNK) push_filler(dshtx_pkg::KIND_TICK);
            wait_drained();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(dshtx_pkg::t_cfg_idx idx, logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            dshtx_pkg::CFG_ONE_HIGH:  cfg_shadow.one_high  = val;
            dshtx_pkg::CFG_ONE_LOW:   cfg_shadow.one_low   = val;
            dshtx_pkg::CFG_ZERO_HIGH: cfg_shadow.zero_high = val;
            dshtx_pkg::CFG_ZERO_LOW:  cfg_shadow.zero_low  = val;
            dshtx_pkg::CFG_MOTOR_CNT: cfg_shadow.motor_cnt = val[2:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [9:0] oh, logic [9:0] ol, logic [9:0] zh,
                                logic [9:0] zl, logic [2:0] mc);
        @(posedge i_clk);
        write_reg(dshtx_pkg::CFG_ONE_HIGH, oh);
        write_reg(dshtx_pkg::CFG_ONE_LOW, ol);
        write_reg(dshtx_pkg::CFG_ZERO_HIGH, zh);
        write_reg(dshtx_pkg::CFG_ZERO_LOW, zl);
        write_reg(dshtx_pkg::CFG_MOTOR_CNT, {7'($urandom), mc});
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int eff_len(logic [9:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    task automatic run_phase(int n_words, output int made);
        logic [9:0] len [4];
        logic [2:0] mc;
        int         per_bit;
        int         frame_ticks;
        int         lim;
        for (int i = 0; i < 4; i++) begin
            len[i] = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(4, 6))
                                                 : 10'($urandom_range(0, 3));
        end
        mc = 3'($urandom_range(0, 7));
        program_regs(len[0], len[1], len[2], len[3], mc);
        per_bit = eff_len(len[0]) + eff_len(len[1]);
        if (eff_len(len[2]) + eff_len(len[3]) > per_bit) per_bit = eff_len(len[2]) + eff_len(len[3]);
        frame_ticks = ((mc > MOTORS) ? MOTORS : int'(mc)) * 16 * per_bit;
        made = 0;
        while (made < n_words) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    push_word(2'($urandom), pick_throttle(), 2'($urandom));
                    made++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_word(dshtx_pkg::KIND_SET, pick_throttle(), 2'($urandom));
                    made++;
                end
                push_filler(dshtx_pkg::KIND_START);
                made++;
                lim = frame_ticks * int'($urandom_range(70, 115)) / 100
                      + int'($urandom_range(0, 3));
                if (lim > n_words - made) lim = n_words - made;
                for (int t = 0; t < lim; t++) begin
                    if ($urandom_range(0, 24) == 0) begin
                        case ($urandom_range(0, 2))
                            0: push_word(dshtx_pkg::KIND_SET, pick_throttle(), 2'($urandom));
                            1: push_filler(dshtx_pkg::KIND_START);
                            default: push_filler(KIND_UNUSED);
                        endcase
                        made++;
                    end
                    push_filler(dshtx_pkg::KIND_TICK);
                    made++;
                end
            end
        end
    endtask

    initial begin
        int made;
        int total;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: no motors enabled
        push_word(dshtx_pkg::KIND_SET, 11'd0, 2'd0);
        push_word(dshtx_pkg::KIND_SET, 11'd2047, 2'd1);
        push_word(dshtx_pkg::KIND_SET, 11'd47, 2'd2);
        push_word(dshtx_pkg::KIND_SET, 11'd48, 2'd3);
        push_filler(dshtx_pkg::KIND_START);
        push_filler(dshtx_pkg::KIND_TICK);
        push_filler(KIND_UNUSED);
        settle();

        // two motors, zero-length high phase for zero bits
        program_regs(10'd3, 10'd1, 10'd0, 10'd2, 3'd2);
        push_word(dshtx_pkg::KIND_SET, 11'd1, 2'd1);
        push_filler(dshtx_pkg::KIND_START);
        repeat (4) push_filler(dshtx_pkg::KIND_TICK);
        push_filler(dshtx_pkg::KIND_START);
        push_word(dshtx_pkg::KIND_SET, 11'd1024, 2'd0);
        push_filler(KIND_UNUSED);
        repeat (4) push_filler(dshtx_pkg::KIND_TICK);
        settle();

        // motor count above the motor total
        program_regs(10'd1, 10'd2, 10'd2, 10'd1, 3'd7);
        push_filler(dshtx_pkg::KIND_START);
        push_word(dshtx_pkg::KIND_SET, 11'd1919, 2'd3);
        settle();

        total = 0;
        while (total < RANDOM_WORDS) begin
            if (total >= RANDOM_WORDS - PHASE_WORDS) calm = 1'b1;
            run_phase(PHASE_WORDS, made);
            total += made;
            rx_hold_req = 1'b1;
            settle();
        end

        // long high phase on a one bit, through the drop to low
        program_regs(10'd600, 10'd0, 10'd0, 10'd0, 3'd1);
        push_word(dshtx_pkg::KIND_SET, 11'd1024, 2'd0);
        push_filler(dshtx_pkg::KIND_START);
        repeat (605) push_filler(dshtx_pkg::KIND_TICK);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0 && status_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/dshtx_pkg.sv
sv/dshtx_encode.sv
sv/dshtx_cfg.sv
sv/dshtx_engine.sv
sv/dshot600_frame_transmitter.sv
verif/tb_top.sv
